// ===== sv/hpem_pkg.sv =====
// ---------------------------------------------------------------------------
// HDR exposure merge package
// Shared constants, defaults and register indexes for the merge block.
// ---------------------------------------------------------------------------
package hpem_pkg;

    localparam int PIXEL_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // integer bits of the weight (Q8.F) and scale (Q2.F) formats
    localparam int WEIGHT_INT_BITS = 8;
    localparam int SCALE_INT_BITS  = 2;

    localparam int CLIP_RESET      = 61000;
    localparam int SPAN_RESET      = 1000;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN       = 3'd4;

    localparam int CFG_DATA_W_DEF = WEIGHT_INT_BITS + FRAC_BITS_DEF;

endpackage

// ===== sv/hpem_if.sv =====
// ---------------------------------------------------------------------------
// HDR exposure merge channel interfaces
// Pixel request, merge result and configuration write channels.
// ---------------------------------------------------------------------------
interface hpem_pix_in_if #(
    parameter int PIXEL_BITS = hpem_pkg::PIXEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] acc_red;
    logic [PIXEL_BITS-1:0] acc_green;
    logic [PIXEL_BITS-1:0] acc_blue;
    logic [PIXEL_BITS-1:0] new_red;
    logic [PIXEL_BITS-1:0] new_green;
    logic [PIXEL_BITS-1:0] new_blue;

    modport source (
        output valid, acc_red, acc_green, acc_blue, new_red, new_green, new_blue,
        input  ready
    );
    modport sink (
        input  valid, acc_red, acc_green, acc_blue, new_red, new_green, new_blue,
        output ready
    );
endinterface

interface hpem_pix_out_if #(
    parameter int PIXEL_BITS = hpem_pkg::PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = hpem_pkg::FRAC_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] out_red;
    logic [PIXEL_BITS-1:0] out_green;
    logic [PIXEL_BITS-1:0] out_blue;
    logic [FRAC_BITS:0]    rolloff_weight;

    modport source (
        output valid, out_red, out_green, out_blue, rolloff_weight,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, rolloff_weight,
        output ready
    );
endinterface

interface hpem_cfg_if #(
    parameter int DATA_W = hpem_pkg::CFG_DATA_W_DEF
);
    logic                           valid;
    logic                           ready;
    logic [hpem_pkg::CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]              data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/hdr_pixel_exposure_merge_unit.sv =====
// ---------------------------------------------------------------------------
// HDR pixel exposure merge unit
// Merges one RGB pixel of a new exposure into the running merge with a clip
// rolloff weight; three channel lanes share one rolloff/weight front end.
// ---------------------------------------------------------------------------
// Pipeline: input register, rolloff divider, weight stages, channel lane
//   stages, channel dividers and lane output registers, then the output
//   register; both dividers resolve one quotient bit per stage.
// Throughput: one pixel per cycle; a two-entry output register/skid pair
//   stalls the pipeline only when both entries are full.
// Reset: synchronous, active low; clears the pipeline and loads the
//   configuration registers with their defaults.
module hdr_pixel_exposure_merge_unit #(
    parameter int PIXEL_BITS = hpem_pkg::PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = hpem_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hpem_cfg_if.sink        i_cfg,
    hpem_pix_in_if.sink     i_pix,
    hpem_pix_out_if.source  o_res
);

    localparam int WW = hpem_pkg::WEIGHT_INT_BITS + FRAC_BITS;
    localparam int SW = hpem_pkg::SCALE_INT_BITS + FRAC_BITS;
    localparam int PW = WW + FRAC_BITS + 1;

    typedef struct packed {
        logic [2:0][PIXEL_BITS-1:0] acc;
        logic [2:0][PIXEL_BITS-1:0] nw;
    } t_pix_side;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] red;
        logic [PIXEL_BITS-1:0] green;
        logic [PIXEL_BITS-1:0] blue;
        logic [FRAC_BITS:0]    roll;
    } t_result;

    // configuration
    logic [WW-1:0]         r_acc_weight;
    logic [SW-1:0]         r_scale;
    logic [WW-1:0]         r_new_weight;
    logic [PIXEL_BITS-1:0] r_clip;
    logic [PIXEL_BITS-1:0] r_span;

    // front end
    logic                  r_in_vld;
    t_pix_side             r_in;
    logic [PIXEL_BITS-1:0] w_max;
    logic [PIXEL_BITS-1:0] w_diff;
    logic [PIXEL_BITS-1:0] w_span;
    logic                  w_rdiv_vld;
    logic [FRAC_BITS-1:0]  w_rdiv_quo;
    logic                  w_rdiv_ovf;
    t_pix_side             w_rdiv_side;

    logic                  r_r1_vld;
    logic [FRAC_BITS:0]    r_r1_roll;
    t_pix_side             r_r1_side;
    logic                  r_r2_vld;
    logic [PW-1:0]         r_r2_prod;
    logic [FRAC_BITS:0]    r_r2_roll;
    t_pix_side             r_r2_side;
    logic                  r_r3_vld;
    logic [WW-1:0]         r_r3_wr;
    logic [WW:0]           r_r3_den;
    logic [FRAC_BITS:0]    r_r3_roll;
    t_pix_side             r_r3_side;

    // lanes and output
    logic [2:0]                 w_lane_vld;
    logic [2:0][PIXEL_BITS-1:0] w_lane_pix;
    logic [FRAC_BITS:0]         w_lane_roll;
    t_result                    w_result;
    logic                       w_res_vld;
    logic                       w_adv;
    logic                       w_take;
    logic                       w_new;
    logic                       r_out_vld;
    t_result                    r_out;
    logic                       r_skid_vld;
    t_result                    r_skid;

    // ---------------- configuration registers ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_weight <= WW'(1 << FRAC_BITS);
            r_scale      <= SW'(1 << FRAC_BITS);
            r_new_weight <= WW'(1 << FRAC_BITS);
            r_clip       <= PIXEL_BITS'(hpem_pkg::CLIP_RESET);
            r_span       <= PIXEL_BITS'(hpem_pkg::SPAN_RESET);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                hpem_pkg::REG_ACC_WEIGHT: r_acc_weight <= i_cfg.data[WW-1:0];
                hpem_pkg::REG_SCALE:      r_scale      <= i_cfg.data[SW-1:0];
                hpem_pkg::REG_NEW_WEIGHT: r_new_weight <= i_cfg.data[WW-1:0];
                hpem_pkg::REG_CLIP:       r_clip       <= i_cfg.data[PIXEL_BITS-1:0];
                hpem_pkg::REG_SPAN:       r_span       <= i_cfg.data[PIXEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    assign w_adv       = !r_skid_vld;
    assign i_pix.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in.acc <= {i_pix.acc_blue, i_pix.acc_green, i_pix.acc_red};
            r_in.nw  <= {i_pix.new_blue, i_pix.new_green, i_pix.new_red};
        end
    end

    // ---------------- rolloff distance ----------------
    always_comb begin
        w_max = r_in.nw[0];
        if (r_in.nw[1] > w_max) begin
            w_max = r_in.nw[1];
        end
        if (r_in.nw[2] > w_max) begin
            w_max = r_in.nw[2];
        end
        w_diff = (r_clip > w_max) ? (r_clip - w_max) : '0;
        w_span = (r_span == '0) ? PIXEL_BITS'(1) : r_span;
    end

    // d*2^F/span; overflow means d >= span, i.e. full weight
    hpem_div_pipe #(
        .NUM_W  (PIXEL_BITS + FRAC_BITS),
        .DEN_W  (PIXEL_BITS),
        .QUO_W  (FRAC_BITS),
        .t_side (t_pix_side)
    ) u_roll_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_in_vld),
        .i_num   ({w_diff, {FRAC_BITS{1'b0}}}),
        .i_den   (w_span),
        .i_side  (r_in),
        .o_valid (w_rdiv_vld),
        .o_quo   (w_rdiv_quo),
        .o_ovf   (w_rdiv_ovf),
        .o_side  (w_rdiv_side)
    );

    // ---------------- weight stages ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_vld <= 1'b0;
            r_r2_vld <= 1'b0;
            r_r3_vld <= 1'b0;
        end else if (w_adv) begin
            r_r1_vld <= w_rdiv_vld;
            r_r2_vld <= r_r1_vld;
            r_r3_vld <= r_r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r1_roll <= w_rdiv_ovf ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, w_rdiv_quo};
            r_r1_side <= w_rdiv_side;
            r_r2_prod <= PW'(r_new_weight) * PW'(r_r1_roll);
            r_r2_roll <= r_r1_roll;
            r_r2_side <= r_r1_side;
            r_r3_wr   <= r_r2_prod[FRAC_BITS +: WW];
            r_r3_den  <= (WW + 1)'(r_acc_weight) + (WW + 1)'(r_r2_prod[FRAC_BITS +: WW]);
            r_r3_roll <= r_r2_roll;
            r_r3_side <= r_r2_side;
        end
    end

    // ---------------- channel lanes ----------------
    for (genvar c = 0; c < 3; c++) begin : g_lane
        if (c == 0) begin : g_roll
            hpem_lane #(
                .PIXEL_BITS (PIXEL_BITS),
                .FRAC_BITS  (FRAC_BITS)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (w_adv),
                .i_valid      (r_r3_vld),
                .i_acc        (r_r3_side.acc[c]),
                .i_new        (r_r3_side.nw[c]),
                .i_wr         (r_r3_wr),
                .i_den        (r_r3_den),
                .i_roll       (r_r3_roll),
                .i_acc_weight (r_acc_weight),
                .i_scale      (r_scale),
                .o_valid      (w_lane_vld[c]),
                .o_pix        (w_lane_pix[c]),
                .o_roll       (w_lane_roll)
            );
        end else begin : g_plain
            hpem_lane #(
                .PIXEL_BITS (PIXEL_BITS),
                .FRAC_BITS  (FRAC_BITS)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (w_adv),
                .i_valid      (r_r3_vld),
                .i_acc        (r_r3_side.acc[c]),
                .i_new        (r_r3_side.nw[c]),
                .i_wr         (r_r3_wr),
                .i_den        (r_r3_den),
                .i_roll       (r_r3_roll),
                .i_acc_weight (r_acc_weight),
                .i_scale      (r_scale),
                .o_valid      (w_lane_vld[c]),
                .o_pix        (w_lane_pix[c]),
                .o_roll       ()
            );
        end
    end

    // ---------------- merge and output register / skid ----------------
    assign w_res_vld = &w_lane_vld;
    assign w_result  = '{red: w_lane_pix[0], green: w_lane_pix[1],
                         blue: w_lane_pix[2], roll: w_lane_roll};

    assign w_take = r_out_vld && o_res.ready;
    assign w_new  = w_adv && w_res_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && !w_take) begin
            if (w_new) begin
                r_skid_vld <= 1'b1;
            end
        end else if (r_skid_vld) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && !w_take) begin
            if (w_new) begin
                r_skid <= w_result;
            end
        end else if (r_skid_vld) begin
            r_out <= r_skid;
        end else begin
            r_out <= w_result;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.out_red        = r_out.red;
    assign o_res.out_green      = r_out.green;
    assign o_res.out_blue       = r_out.blue;
    assign o_res.rolloff_weight = r_out.roll;

endmodule

// ===== sv/hpem_div_pipe.sv =====
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage. Flags overflow when the quotient does not fit
// in QUO_W bits; a sideband word travels with each request.
// ---------------------------------------------------------------------------
module hpem_div_pipe #(
    parameter int  NUM_W = 32,
    parameter int  DEN_W = 16,
    parameter int  QUO_W = 16,
    parameter type t_side = logic
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_ovf,
    output t_side            o_side
);

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [CMP_W-1:0] w_hi;
    logic [CMP_W-1:0] w_den;

    logic             r_vld  [0:QUO_W];
    logic             r_ovf  [0:QUO_W];
    t_side            r_side [0:QUO_W];
    logic [DEN_W-1:0] r_rem  [0:QUO_W-1];
    logic [DEN_W-1:0] r_den  [0:QUO_W-1];
    logic [QUO_W-1:0] r_low  [0:QUO_W-1];
    logic [QUO_W-1:0] r_quo  [1:QUO_W];

    assign w_hi  = CMP_W'(i_num[NUM_W-1:QUO_W]);
    assign w_den = CMP_W'(i_den);

    // entry stage: quotient overflows when the upper part already reaches den
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0]  <= (w_hi >= w_den);
            r_rem[0]  <= w_hi[DEN_W-1:0];
            r_den[0]  <= i_den;
            r_low[0]  <= i_num[QUO_W-1:0];
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0] w_trial;
        logic [DEN_W:0] w_sub;
        logic           w_ge;

        assign w_trial = {r_rem[k-1], r_low[k-1][QUO_W-1]};
        assign w_sub   = w_trial - {1'b0, r_den[k-1]};
        assign w_ge    = (w_trial >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end

        if (k == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[k] <= QUO_W'(w_ge);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[k] <= {r_quo[k-1][QUO_W-2:0], w_ge};
                end
            end
        end

        if (k < QUO_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_den[k] <= r_den[k-1];
                    r_low[k] <= {r_low[k-1][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_quo   = r_quo[QUO_W];
    assign o_ovf   = r_ovf[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule

// ===== sv/hpem_lane.sv =====
// ---------------------------------------------------------------------------
// HDR merge channel lane
// Weighted average of one color channel: scale the new sample, form the
// numerator, divide by the combined weight, round and saturate.
// ---------------------------------------------------------------------------
module hpem_lane #(
    parameter int PIXEL_BITS = hpem_pkg::PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = hpem_pkg::FRAC_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_en,
    input  logic                                              i_valid,
    input  logic [PIXEL_BITS-1:0]                             i_acc,
    input  logic [PIXEL_BITS-1:0]                             i_new,
    input  logic [hpem_pkg::WEIGHT_INT_BITS+FRAC_BITS-1:0]    i_wr,
    input  logic [hpem_pkg::WEIGHT_INT_BITS+FRAC_BITS:0]      i_den,
    input  logic [FRAC_BITS:0]                                i_roll,
    input  logic [hpem_pkg::WEIGHT_INT_BITS+FRAC_BITS-1:0]    i_acc_weight,
    input  logic [hpem_pkg::SCALE_INT_BITS+FRAC_BITS-1:0]     i_scale,
    output logic                                              o_valid,
    output logic [PIXEL_BITS-1:0]                             o_pix,
    output logic [FRAC_BITS:0]                                o_roll
);

    localparam int WW     = hpem_pkg::WEIGHT_INT_BITS + FRAC_BITS;
    localparam int SW     = hpem_pkg::SCALE_INT_BITS + FRAC_BITS;
    localparam int SUM_W  = PIXEL_BITS + SW + 1;
    localparam int SN_W   = PIXEL_BITS + 2;
    localparam int PA_W   = PIXEL_BITS + WW;
    localparam int PS_W   = SN_W + WW;
    localparam int NUM_W  = PIXEL_BITS + FRAC_BITS + 11;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] acc;
        logic [WW-1:0]         wr;
        logic [WW:0]           den;
        logic [FRAC_BITS:0]    roll;
    } t_pass;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] acc;
        logic                  den_zero;
        logic [FRAC_BITS:0]    roll;
    } t_lside;

    logic [3:0]             r_vld;
    t_pass                  r_pass [0:3];
    logic [PA_W-1:0]        r_prod_acc [0:2];
    logic [PIXEL_BITS+SW-1:0] r_prod_new;
    logic [SN_W-1:0]        r_sn;
    logic [PS_W-1:0]        r_prod_sn;
    logic [NUM_W-1:0]       r_num;
    logic                   r_out_vld;
    logic [PIXEL_BITS-1:0]  r_pix;
    logic [FRAC_BITS:0]     r_roll;

    logic [SUM_W-1:0]       w_sn_sum;
    t_lside                 w_side_in;
    logic                   w_div_vld;
    logic [PIXEL_BITS-1:0]  w_quo;
    logic                   w_ovf;
    t_lside                 w_side_out;

    // round the scaled sample back to pixel units (plus two headroom bits)
    assign w_sn_sum = SUM_W'(r_prod_new) + SUM_W'(1 << (FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // products
            r_pass[0]     <= '{acc: i_acc, wr: i_wr, den: i_den, roll: i_roll};
            r_prod_acc[0] <= PA_W'(i_acc) * PA_W'(i_acc_weight);
            r_prod_new    <= (PIXEL_BITS + SW)'(i_new) * (PIXEL_BITS + SW)'(i_scale);
            // rounding
            r_pass[1]     <= r_pass[0];
            r_prod_acc[1] <= r_prod_acc[0];
            r_sn          <= w_sn_sum[FRAC_BITS +: SN_W];
            // weighted new sample
            r_pass[2]     <= r_pass[1];
            r_prod_acc[2] <= r_prod_acc[1];
            r_prod_sn     <= PS_W'(r_sn) * PS_W'(r_pass[1].wr);
            // numerator with half-divisor rounding term
            r_pass[3]     <= r_pass[2];
            r_num         <= NUM_W'(r_prod_acc[2]) + NUM_W'(r_prod_sn)
                           + NUM_W'(r_pass[2].den >> 1);
        end
    end

    assign w_side_in = '{acc: r_pass[3].acc, den_zero: (r_pass[3].den == '0),
                         roll: r_pass[3].roll};

    hpem_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (WW + 1),
        .QUO_W  (PIXEL_BITS),
        .t_side (t_lside)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vld[3]),
        .i_num   (r_num),
        .i_den   (r_pass[3].den),
        .i_side  (w_side_in),
        .o_valid (w_div_vld),
        .o_quo   (w_quo),
        .o_ovf   (w_ovf),
        .o_side  (w_side_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= w_div_vld;
        end
    end

    // zero weight passes the running pixel; quotient overflow saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_roll <= w_side_out.roll;
            if (w_side_out.den_zero) begin
                r_pix <= w_side_out.acc;
            end else if (w_ovf) begin
                r_pix <= '1;
            end else begin
                r_pix <= w_quo;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_pix   = r_pix;
    assign o_roll  = r_roll;

endmodule
